// ===== rtl/core/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest pair package
// Types shared by the point cells, the result collector and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  // Width of one coordinate and of a Manhattan distance.
  localparam int unsigned CoordW = 32;
  localparam int unsigned DistW  = CoordW + 1;

  // Distance that marks "no pair compared yet"; above every real distance.
  localparam logic [DistW-1:0] DistNone = '1;

  // One input transaction.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } point_in_t;

  // One result transaction.
  typedef struct packed {
    logic [DistW-1:0] min_manhattan;
    logic             no_pair;
    logic             capacity_overflow;
  } result_t;

  // A point travelling down the cell row with its running minimum.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     placed;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [DistW-1:0]         best;
  } token_t;

endpackage : cpm_pkg

`default_nettype wire

// ===== rtl/core/cpm_cell.sv =====
// ----------------------------------------------------------------------------
// Closest pair point cell
// Holds at most one point. A passing point is compared with the held one in
// two register stages, or is captured when the cell is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_cell
  import cpm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   adv_i,
  input  wire token_t tok_i,
  output token_t      tok_o
);

  logic                     full_q, full_d;
  logic signed [CoordW-1:0] pt_x_q, pt_y_q;
  token_t                   s1_tok_q, s1_tok_d;
  logic                     s1_cmp_q, s1_cmp_d;
  logic [CoordW-1:0]        adx_q, adx_d, ady_q, ady_d;
  token_t                   s2_tok_q, s2_tok_d;
  logic                     capture;
  logic [DistW-1:0]         dist_sum;

  // Stage one: absolute coordinate differences and the capture decision.
  always_comb begin
    capture  = tok_i.valid && !tok_i.placed && !full_q;
    s1_cmp_d = tok_i.valid && !tok_i.placed && full_q;
    adx_d    = (tok_i.x > pt_x_q) ? CoordW'(tok_i.x - pt_x_q) : CoordW'(pt_x_q - tok_i.x);
    ady_d    = (tok_i.y > pt_y_q) ? CoordW'(tok_i.y - pt_y_q) : CoordW'(pt_y_q - tok_i.y);
    s1_tok_d = tok_i;
    if (capture) begin
      s1_tok_d.placed = 1'b1;
    end
    // The closing point of a set empties every cell it passes.
    full_d = full_q;
    if (tok_i.valid && tok_i.last) begin
      full_d = 1'b0;
    end else if (capture) begin
      full_d = 1'b1;
    end
  end

  // Stage two: sum the differences and keep the smaller distance.
  always_comb begin
    dist_sum = DistW'(adx_q) + DistW'(ady_q);
    s2_tok_d = s1_tok_q;
    if (s1_cmp_q && (dist_sum < s1_tok_q.best)) begin
      s2_tok_d.best = dist_sum;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= 1'b0;
      s1_tok_q <= '0;
      s1_cmp_q <= 1'b0;
      s2_tok_q <= '0;
    end else if (adv_i) begin
      full_q   <= full_d;
      s1_tok_q <= s1_tok_d;
      s1_cmp_q <= s1_cmp_d;
      s2_tok_q <= s2_tok_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      adx_q <= adx_d;
      ady_q <= ady_d;
      if (capture) begin
        pt_x_q <= tok_i.x;
        pt_y_q <= tok_i.y;
      end
    end
  end

  assign tok_o = s2_tok_q;

endmodule : cpm_cell

`default_nettype wire

// ===== rtl/core/cpm_collect.sv =====
// ----------------------------------------------------------------------------
// Closest pair result collector
// Merges the running minima of points leaving the cell row, counts stored
// points, notes dropped ones and presents the result of each set.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_collect
  import cpm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire token_t tok_i,
  output logic        adv_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output result_t     out_data_o
);

  logic [DistW-1:0] best_q, best_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_data_q, out_data_d;
  logic             take;
  logic             no_pair;

  // The row only halts when a finished set cannot leave the result register.
  assign adv_o = !(tok_i.valid && tok_i.last && out_valid_q && out_stall_i);
  assign take  = adv_o && tok_i.valid;

  // Accumulate over the set and close it on its last point.
  always_comb begin
    best_d      = best_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    no_pair     = 1'b0;
    if (take) begin
      if (tok_i.placed) begin
        if (tok_i.best < best_d) begin
          best_d = tok_i.best;
        end
        if (cnt_d != 2'd2) begin
          cnt_d = cnt_d + 2'd1;
        end
      end else begin
        ovf_d = 1'b1;
      end
      if (tok_i.last) begin
        no_pair                      = (cnt_d != 2'd2);
        out_valid_d                  = 1'b1;
        out_data_d.no_pair           = no_pair;
        out_data_d.min_manhattan     = no_pair ? '0 : best_d;
        out_data_d.capacity_overflow = ovf_d;
        best_d                       = DistNone;
        cnt_d                        = '0;
        ovf_d                        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= DistNone;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : cpm_collect

`default_nettype wire

// ===== rtl/core/closest_pair_manhattan_top.sv =====
// ----------------------------------------------------------------------------
// Closest pair of points, Manhattan metric
// Row of point cells that finds the smallest |dx| + |dy| over a set of points.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid_i/in_stall_o  point_in_t (x, y, last flag)
//  out       output     out_valid_o/out_stall_i result_t (distance, flags)
//
//  One point is taken every cycle while the input is not stalled; each
//  point passes through two register stages per cell, and a set's result
//  is registered in the collector once its last point leaves the row.
//  Reset empties all cells and the collector at once. The input stalls only
//  while a closing point waits behind an unaccepted result.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_manhattan_top
  import cpm_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire point_in_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output result_t        out_data_o
);

  token_t chain[MAX_POINTS+1];
  token_t in_tok;
  logic   adv;

  // Turn an input transaction into a token entering the first cell.
  always_comb begin
    in_tok.valid  = in_valid_i;
    in_tok.last   = in_data_i.last_point;
    in_tok.placed = 1'b0;
    in_tok.x      = in_data_i.point_x;
    in_tok.y      = in_data_i.point_y;
    in_tok.best   = DistNone;
  end

  assign chain[0]   = in_tok;
  assign in_stall_o = !adv;

  // Row of point cells.
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    cpm_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  // Result collection at the end of the row.
  cpm_collect u_collect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (chain[MAX_POINTS]),
    .adv_o      (adv),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule : closest_pair_manhattan_top

`default_nettype wire

// ===== verif/closest_pair_manhattan_top_test.sv =====
// ----------------------------------------------------------------------------
// Closest pair of points, Manhattan metric: self-checking testbench
// Sends sets of points through the input channel and rebuilds each set's
// smallest |dx| + |dy| in a local model that is updated on every accepted
// transaction. Result transactions are compared field by field, in order, with
// the model. A short table of hand-picked points comes first. Random sets
// follow under changing sender and receiver idling, and include a set that
// overruns the point store.
// ----------------------------------------------------------------------------

module closest_pair_manhattan_top_test;
  import cpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPoints     = 1024;
  localparam int          HoldoffCycles = 6000;
  localparam int          MaxPrinted    = 100;

  localparam logic signed [CoordW-1:0] XMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] XMax = 32'sh7FFF_FFFF;

  // Distances across the whole plane and across one axis.
  localparam logic [DistW-1:0] FullSpan = 33'h1_FFFF_FFFE;
  localparam logic [DistW-1:0] AxisSpan = 33'h0_FFFF_FFFF;

  // Running minimum before any pair has been compared.
  localparam longint NoGap = 64'h3_FFFF_FFFF;

  typedef enum int {NearOrigin, AnyValue, Corner, NearCentre} coord_style_e;

  // One row of the directed table.
  typedef struct {
    point_in_t pt;
    bit        typed;
    result_t   want;
  } stim_row_t;

  // Note left by the sender for each closing point it offers.
  typedef struct {
    bit      typed;
    result_t want;
  } closing_note_t;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_stall;
  point_in_t in_point   = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  result_t   out_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_req    = 0;
  int holdoff_seen   = 0;
  int holdoff_left   = 0;
  int items_offered  = 0;
  int mismatch_count = 0;

  stim_row_t     directed_rows[$];
  closing_note_t closing_notes[$];
  result_t       pending_minima[$];

  // Model of the current set: the stored points, the smallest distance so
  // far and whether a point was dropped.
  longint held_x[$];
  longint held_y[$];
  longint best_gap = NoGap;
  bit     spilled  = 1'b0;

  always #4 clk = ~clk;

  closest_pair_manhattan_top #(
    .MAX_POINTS(MaxPoints)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_point),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_result)
  );

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Folds one accepted point into the set model. On a closing point the
  // set's result is returned and the model starts a new set.
  function automatic void merge_point(input point_in_t pt, output bit closed,
                                      output result_t res);
    longint px;
    longint py;
    longint dx;
    longint dy;
    px = $signed(pt.point_x);
    py = $signed(pt.point_y);
    closed = 1'b0;
    res = '0;
    if (held_x.size() < MaxPoints) begin
      foreach (held_x[k]) begin
        dx = px - held_x[k];
        dy = py - held_y[k];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx + dy < best_gap) best_gap = dx + dy;
      end
      held_x = {held_x, px};
      held_y = {held_y, py};
    end else begin
      spilled = 1'b1;
    end
    if (pt.last_point) begin
      closed = 1'b1;
      if (held_x.size() < 2) begin
        res.min_manhattan = '0;
        res.no_pair = 1'b1;
      end else begin
        res.min_manhattan = DistW'(best_gap);
        res.no_pair = 1'b0;
      end
      res.capacity_overflow = spilled;
      held_x.delete();
      held_y.delete();
      best_gap = NoGap;
      spilled = 1'b0;
    end
  endfunction

  // Watches both channels. Accepted points feed the model; accepted results
  // are checked against the oldest expected minimum.
  always @(posedge clk) begin : watch
    bit            closed;
    result_t       model_res;
    result_t       want;
    closing_note_t note;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        merge_point(in_point, closed, model_res);
        if (closed) begin
          note = closing_notes.pop_front();
          if (note.typed) model_res = note.want;
          pending_minima = {pending_minima, model_res};
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_minima.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_minima.pop_front();
          if (out_result.min_manhattan !== want.min_manhattan) begin
            flag_mismatch($sformatf("min_manhattan got %0d expected %0d",
                                    out_result.min_manhattan, want.min_manhattan));
          end
          if (out_result.no_pair !== want.no_pair) begin
            flag_mismatch($sformatf("no_pair got %b expected %b",
                                    out_result.no_pair, want.no_pair));
          end
          if (out_result.capacity_overflow !== want.capacity_overflow) begin
            flag_mismatch($sformatf("capacity_overflow got %b expected %b",
                                    out_result.capacity_overflow,
                                    want.capacity_overflow));
          end
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when the sender asks.
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one point after a random idle gap and returns once it is taken.
  task automatic offer_point(input point_in_t pt, input bit typed, input result_t want);
    closing_note_t note;
    point_in_t     junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk.point_x = $urandom();
      junk.point_y = $urandom();
      junk.last_point = $urandom_range(1);
      in_valid <= 1'b0;
      in_point <= junk;
      @(posedge clk);
    end
    if (pt.last_point) begin
      note.typed = typed;
      note.want = want;
      closing_notes = {closing_notes, note};
    end
    in_valid <= 1'b1;
    in_point <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has come back. The
  // first edge lets the watcher record a closing point taken at the last one.
  task automatic wait_for_minima();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_minima.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord(input coord_style_e style,
                                                          input logic signed [CoordW-1:0] centre);
    case (style)
      NearOrigin: return $urandom_range(40) - 20;
      AnyValue:   return $urandom();
      Corner: begin
        case ($urandom_range(5))
          0:       return XMin;
          1:       return XMax;
          2:       return 0;
          3:       return -1;
          4:       return XMin + 1;
          default: return XMax - 1;
        endcase
      end
      default:    return centre + $urandom_range(2000) - 1000;
    endcase
  endfunction

  // One random set of the given size, closed by its last point. Most points
  // follow the set's coordinate style so that close pairs are common.
  task automatic offer_random_set(input int count);
    point_in_t                 pt;
    result_t                   none;
    coord_style_e              set_style;
    coord_style_e              style;
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    none = '0;
    set_style = coord_style_e'($urandom_range(3));
    cx = $urandom();
    cy = $urandom();
    for (int k = 0; k < count; k++) begin
      style = ($urandom_range(9) < 7) ? set_style : coord_style_e'($urandom_range(3));
      pt.point_x = pick_coord(style, cx);
      pt.point_y = pick_coord(style, cy);
      pt.last_point = (k == count - 1);
      offer_point(pt, 1'b0, none);
    end
    items_offered += count;
  endtask

  // Random sets, mostly small, until about the given number of points.
  task automatic run_random_sets(input int goal);
    int start;
    int count;
    int pick;
    start = items_offered;
    while (items_offered - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) count = 1;
      else if (pick < 80) count = $urandom_range(8, 2);
      else if (pick < 95) count = $urandom_range(24, 9);
      else count = $urandom_range(60, 25);
      offer_random_set(count);
    end
  endtask

  task automatic add_row(input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y,
                         input bit last, input bit typed, input logic [DistW-1:0] gap,
                         input bit lone);
    stim_row_t row;
    row.pt.point_x = x;
    row.pt.point_y = y;
    row.pt.last_point = last;
    row.typed = typed;
    row.want.min_manhattan = gap;
    row.want.no_pair = lone;
    row.want.capacity_overflow = 1'b0;
    directed_rows = {directed_rows, row};
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A lone point gives no pair, with all-zero and all-ones coordinates.
    add_row(0, 0, 1, 1, '0, 1);
    add_row(-1, -1, 1, 1, '0, 1);
    // Opposite corners of the plane give the largest distance.
    add_row(XMin, XMin, 0, 0, '0, 0);
    add_row(XMax, XMax, 1, 1, FullSpan, 0);
    add_row(XMax, XMin, 0, 0, '0, 0);
    add_row(XMin, XMax, 1, 1, FullSpan, 0);
    // Full span along one axis only.
    add_row(XMin, 0, 0, 0, '0, 0);
    add_row(XMax, 0, 1, 1, AxisSpan, 0);
    add_row(0, XMax, 0, 0, '0, 0);
    add_row(0, XMin, 1, 1, AxisSpan, 0);
    // A repeated point is at distance zero.
    add_row(5, -3, 0, 0, '0, 0);
    add_row(5, -3, 1, 1, '0, 0);
    // Small clusters, checked by the model.
    add_row(-1, -1, 0, 0, '0, 0);
    add_row(100, 100, 0, 0, '0, 0);
    add_row(1, 1, 0, 0, '0, 0);
    add_row(0, 0, 1, 0, '0, 0);
    add_row(XMax, XMax, 0, 0, '0, 0);
    add_row(XMin, XMin, 0, 0, '0, 0);
    add_row(XMax - 1, XMax, 0, 0, '0, 0);
    add_row(32'sh5555_5555, 32'shAAAA_AAAA, 1, 0, '0, 0);
    foreach (directed_rows[i]) begin
      offer_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_minima();

    // No idling, plus a set that fills the point store and overruns it,
    // including a dropped closing point.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_sets(80);
    offer_random_set(MaxPoints + 2);
    wait_for_minima();

    // Sender mostly idle.
    send_idle_pct = 83;
    run_random_sets(80);
    wait_for_minima();

    // Receiver mostly stalling.
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_random_sets(80);
    wait_for_minima();

    // Light idling on both sides.
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random_sets(80);
    wait_for_minima();

    // Long receiver hold-off while points keep coming, so the row backs up.
    send_idle_pct = 83;
    recv_stall_pct = 0;
    holdoff_req++;
    run_random_sets(450);
    wait_for_minima();

    // Let any stray result show up before the verdict.
    repeat (2 * MaxPoints + 64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cpm_pkg.sv
rtl/core/cpm_cell.sv
rtl/core/cpm_collect.sv
rtl/core/closest_pair_manhattan_top.sv
verif/closest_pair_manhattan_top_test.sv
